### sv/round_robin_queue_with_expedite_core_assert.svh
// Assertion macros for the round-robin queue checker.
// Expects clk and rst_n in the scope of each use.
`ifndef ROUND_ROBIN_QUEUE_WITH_EXPEDITE_CORE_ASSERT_SVH
`define ROUND_ROBIN_QUEUE_WITH_EXPEDITE_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RRQE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked from the cycle after the antecedent
`define RRQE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rrqe_pkg.sv
// Shared constants and types for the round-robin queue with expedite.
// No dependencies; imported by the interfaces and every module.
package rrqe_pkg;

  localparam int DEPTH = 1024;
  localparam int ID_W  = 30;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // match scan: cells are grouped, suffix-OR inside and across groups
  localparam int GRP  = 32;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;
  localparam int PAD  = NGRP * GRP;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam logic OP_SERVE    = 1'b0;
  localparam logic OP_EXPEDITE = 1'b1;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic load;    // reload 1..min(population, DEPTH)
    logic rotate;  // front to back
    logic cmp;     // latch key match
    logic insert;  // shift right where enabled, new id into cell 0
  } cell_ctl_t;

endpackage

### sv/rrqe_if.sv
// Valid/ready channel interfaces: input items, result items, configuration.
// Depends on rrqe_pkg.
interface rrqe_in_if import rrqe_pkg::*; ();
  logic valid;
  logic ready;
  logic op;
  id_t  item_id;
  modport source (output valid, output op, output item_id, input ready);
  modport sink   (input valid, input op, input item_id, output ready);
endinterface

interface rrqe_out_if import rrqe_pkg::*; ();
  logic valid;
  logic ready;
  id_t  served_id;
  logic overflowed;
  modport source (output valid, output served_id, output overflowed, input ready);
  modport sink   (input valid, input served_id, input overflowed, output ready);
endinterface

interface rrqe_cfg_if import rrqe_pkg::*; ();
  logic valid;
  logic ready;
  id_t  population;
  modport source (output valid, output population, input ready);
  modport sink   (input valid, input population, output ready);
endinterface

### sv/rrqe_cell.sv
// One queue slot: identifier, valid bit and latched key match.
// Depends on rrqe_pkg; instantiated DEPTH times by the top level.
module rrqe_cell import rrqe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  idx_t      idx,
  input  cell_ctl_t ctl,
  input  id_t       pop,
  input  id_t       key,
  input  id_t       front,
  input  id_t       pred_data,
  input  logic      pred_valid,
  input  id_t       succ_data,
  input  logic      succ_valid,
  input  logic      shift_en,
  output id_t       data_o,
  output logic      valid_o,
  output logic      match_o
);

  id_t  data_r;
  logic valid_r;
  logic match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r  <= id_t'(idx) + id_t'(1);
      valid_r <= (idx == '0);
      match_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        data_r  <= id_t'(idx) + id_t'(1);
        valid_r <= (pop > id_t'(idx));
      end else if (ctl.rotate) begin
        // the tail cell takes the old front, the rest advance
        if (valid_r) begin
          data_r <= succ_valid ? succ_data : front;
        end
      end else if (ctl.insert && shift_en) begin
        data_r  <= pred_data;
        valid_r <= pred_valid;
      end
      if (ctl.cmp) begin
        match_r <= valid_r && (data_r == key);
      end
    end
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;
  assign match_o = match_r;

endmodule

### sv/rrqe_scan.sv
// Registered suffix-OR of the cell match bits, in groups of GRP cells.
// Depends on rrqe_pkg; suf[i] is high when a match sits at cell i or behind it.
module rrqe_scan import rrqe_pkg::*; (
  input  logic             clk,
  input  logic             strobe,
  input  logic [DEPTH-1:0] match,
  output logic [DEPTH-1:0] suf
);

  logic [PAD-1:0]   match_pad;
  logic [DEPTH-1:0] loc_nxt;
  logic [DEPTH-1:0] loc_r;
  logic [NGRP-1:0]  any_nxt;
  logic [NGRP-1:0]  any_r;

  assign match_pad = PAD'(match);

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    assign any_nxt[g] = |match_pad[g*GRP +: GRP];
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_bit
    localparam int G = i / GRP;
    localparam int K = i % GRP;
    assign loc_nxt[i] = |(match_pad[G*GRP +: GRP] >> K);
    // groups further back contribute as a whole
    assign suf[i]     = loc_r[i] | (|(any_r >> (G + 1)));
  end

  always_ff @(posedge clk) begin
    if (strobe) begin
      loc_r <= loc_nxt;
      any_r <= any_nxt;
    end
  end

endmodule

### sv/round_robin_queue_with_expedite_core.sv
// Round-robin identifier queue with expedite, built as a row of DEPTH cells.
// Depends on rrqe_pkg, rrqe_if, rrqe_cell and rrqe_scan.
//
//   channel  | dir | handshake     | payload
//   in_if    | in  | valid / ready | op, item_id
//   out_if   | out | valid / ready | served_id, overflowed
//   cfg_if   | in  | valid / ready | population (reloads the queue)
//
// Serve next: every valid cell takes its successor's entry (the last one the old front)
//   in the same edge, the result sits in the output register from the next cycle.
// Expedite: follows the match path in order: compare in every cell, a registered
//   suffix-OR over the cells, then one shift of the row.
// Input is taken only in idle with the output register free or being taken.
// Reset (synchronous) loads identifier 1 alone and clears the overflow flag;
//   a population write reloads the row.
module round_robin_queue_with_expedite_core import rrqe_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  rrqe_in_if.sink        in_if,
  rrqe_out_if.source     out_if,
  rrqe_cfg_if.sink       cfg_if
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

  logic in_valid;
  logic in_ready;
  logic in_op;
  id_t  in_item_id;
  logic out_valid;
  logic out_ready;
  id_t  out_served_id;
  logic out_overflowed;
  logic cfg_valid;
  logic cfg_ready;

  state_t    state_r;
  logic      out_valid_r;
  id_t       served_r;
  logic      ovf_out_r;
  logic      overflow_r;
  id_t       id_r;

  cell_ctl_t        ctl;
  logic             in_acc;
  logic             found;
  id_t              cell_data [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] match_vec;
  logic [DEPTH-1:0] suf;
  logic [DEPTH-1:0] shift_en;

  assign in_valid   = in_if.valid;
  assign in_op      = in_if.op;
  assign in_item_id = in_if.item_id;
  assign in_if.ready = in_ready;

  assign out_ready         = out_if.ready;
  assign out_valid         = out_valid_r;
  assign out_served_id     = served_r;
  assign out_overflowed    = ovf_out_r;
  assign out_if.valid      = out_valid;
  assign out_if.served_id  = out_served_id;
  assign out_if.overflowed = out_overflowed;

  assign cfg_valid    = cfg_if.valid;
  assign cfg_ready    = 1'b1;
  assign cfg_if.ready = cfg_ready;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    ctl        = '0;
    ctl.load   = cfg_valid && cfg_ready;
    ctl.rotate = in_acc && (in_op == OP_SERVE) && cell_valid[0];
    ctl.cmp    = in_acc && (in_op == OP_EXPEDITE);
    ctl.insert = (state_r == S_APPLY);
  end

  // absent id: whole row moves back; present id: only cells up to the match
  assign found    = suf[0];
  assign shift_en = found ? suf : '1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    id_t  pred_data;
    logic pred_valid;
    id_t  succ_data;
    logic succ_valid;

    if (i == 0) begin : g_head
      assign pred_data  = id_r;
      assign pred_valid = 1'b1;
    end else begin : g_mid_pred
      assign pred_data  = cell_data[i-1];
      assign pred_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign succ_data  = '0;
      assign succ_valid = 1'b0;
    end else begin : g_mid_succ
      assign succ_data  = cell_data[i+1];
      assign succ_valid = cell_valid[i+1];
    end

    rrqe_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .idx        (IDX_W'(i)),
      .ctl        (ctl),
      .pop        (cfg_if.population),
      .key        (in_item_id),
      .front      (cell_data[0]),
      .pred_data  (pred_data),
      .pred_valid (pred_valid),
      .succ_data  (succ_data),
      .succ_valid (succ_valid),
      .shift_en   (shift_en[i]),
      .data_o     (cell_data[i]),
      .valid_o    (cell_valid[i]),
      .match_o    (match_vec[i])
    );
  end

  rrqe_scan u_scan (
    .clk    (clk),
    .strobe (state_r == S_SCAN),
    .match  (match_vec),
    .suf    (suf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      overflow_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctl.cmp) begin
            id_r    <= in_item_id;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          // a new id into a full row pushes the tail out
          if (!found && cell_valid[DEPTH-1]) begin
            overflow_r <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (ctl.rotate) begin
        out_valid_r <= 1'b1;
        served_r    <= cell_data[0];
        ovf_out_r   <= overflow_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### sv/rrqe_checker.sv
// Port-level checks for the round-robin queue, bound to the top level.
// Depends on rrqe_pkg and round_robin_queue_with_expedite_core_assert.svh.
`include "round_robin_queue_with_expedite_core_assert.svh"

module rrqe_checker import rrqe_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready,
  input id_t  out_served_id,
  input logic out_overflowed
);

  logic seen_ovf_r;

  // remember any delivered result that carried the overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_ovf_r <= 1'b0;
    end else if (out_valid && out_ready && out_overflowed) begin
      seen_ovf_r <= 1'b1;
    end
  end

  `RRQE_ASSERT_SAME(a_ovf_sticky, out_valid && seen_ovf_r, out_overflowed, "overflow flag fell")
  `RRQE_ASSERT_NEXT(a_exp_busy, in_valid && in_ready && (in_op == OP_EXPEDITE), !in_ready ##1 !in_ready, "item taken during expedite")
  `RRQE_ASSERT_SAME(a_no_overrun, in_valid && in_ready, !out_valid || out_ready, "item taken with result slot full")
  `RRQE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_served_id), "stalled result changed")

endmodule

bind round_robin_queue_with_expedite_core rrqe_checker u_rrqe_checker (.*);

### dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for the round-robin identifier queue with expedite (move to front).
// Drives serve-next and expedite items, predicts each served identifier and the
// overflow flag; depends on rrqe_pkg, the rrqe_if interfaces and the core.
module testbench;
  import rrqe_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_GAP   = 8;
  localparam int IDLE_PERCENT = 22;
  localparam id_t ID_MAX      = {ID_W{1'b1}};

  typedef struct packed {
    logic op;
    id_t  item_id;
  } queue_cmd_t;

  typedef struct packed {
    id_t  served_id;
    logic overflowed;
  } serve_result_t;

  bit   clk = 1'b0;
  logic rst_n = 1'b0;

  rrqe_in_if  in_if();
  rrqe_out_if out_if();
  rrqe_cfg_if cfg_if();

  round_robin_queue_with_expedite_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  queue_cmd_t    cmd_backlog_q[$];
  serve_result_t serve_expect_q[$];
  id_t           rotation_q[$];
  bit            overflow_model;
  int            cmds_outstanding;
  int            mismatches;
  int            cycle_count;
  bit            no_gaps;
  bit            in_fire;
  bit            cfg_fire;
  queue_cmd_t    next_cmd;
  serve_result_t oldest_serve;

  function automatic void reload_rotation(id_t population);
    int count;
    count = (population < DEPTH) ? int'(population) : DEPTH;
    rotation_q.delete();
    for (int k = 1; k <= count; k++) rotation_q.insert(rotation_q.size(), id_t'(k));
  endfunction

  function automatic void apply_cmd(logic op, id_t id);
    int   hit;
    id_t  front;
    hit = -1;
    if (op == OP_SERVE) begin
      // empty queue: nothing served
      if (rotation_q.size() == 0) return;
      front = rotation_q[0];
      rotation_q.delete(0);
      rotation_q.insert(rotation_q.size(), front);
      serve_expect_q.insert(serve_expect_q.size(),
                            serve_result_t'{served_id: front, overflowed: overflow_model});
    end else begin
      foreach (rotation_q[k]) if (hit < 0 && rotation_q[k] == id) hit = k;
      if (hit >= 0) begin
        rotation_q.delete(hit);
      end else if (rotation_q.size() >= DEPTH) begin
        // full: drop the tail
        rotation_q.delete(rotation_q.size() - 1);
        overflow_model = 1'b1;
      end
      rotation_q.insert(0, id);
    end
  endfunction

  // monitor: sample all handshakes at the rising edge
  always @(posedge clk) begin
    in_fire  = 1'b0;
    cfg_fire = 1'b0;
    cycle_count++;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        cfg_fire = 1'b1;
        reload_rotation(cfg_if.population);
      end
      if (out_if.valid && out_if.ready) begin
        if (serve_expect_q.size() == 0) begin
          $error("result item with nothing expected: served_id %0d overflowed %0d",
                 out_if.served_id, out_if.overflowed);
          mismatches++;
        end else begin
          oldest_serve = serve_expect_q[0];
          serve_expect_q.delete(0);
          if (out_if.served_id !== oldest_serve.served_id) begin
            $error("served_id: expected %0d, actual %0d",
                   oldest_serve.served_id, out_if.served_id);
            mismatches++;
          end
          if (out_if.overflowed !== oldest_serve.overflowed) begin
            $error("overflowed: expected %0d, actual %0d",
                   oldest_serve.overflowed, out_if.overflowed);
            mismatches++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        in_fire = 1'b1;
        cmds_outstanding--;
        apply_cmd(in_if.op, in_if.item_id);
      end
    end
  end

  // driver: change inputs on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      out_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
      if (!in_if.valid || in_fire) begin
        if (cmd_backlog_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
          next_cmd = cmd_backlog_q[0];
          cmd_backlog_q.delete(0);
          in_if.valid   <= 1'b1;
          in_if.op      <= next_cmd.op;
          in_if.item_id <= next_cmd.item_id;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic send(logic op, id_t id);
    cmd_backlog_q.insert(cmd_backlog_q.size(), queue_cmd_t'{op: op, item_id: id});
    cmds_outstanding++;
  endtask

  // hold until every item is taken and every result is out, then let expedites settle
  task automatic wait_idle(int settle);
    do @(negedge clk); while (cmds_outstanding != 0 || serve_expect_q.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_population(id_t value);
    wait_idle(SETTLE_GAP);
    cfg_if.valid      <= 1'b1;
    cfg_if.population <= value;
    do @(negedge clk); while (!cfg_fire);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(id_t population, int n_items);
    int count;
    int span;
    int pick;
    write_population(population);
    count = (population < DEPTH) ? int'(population) : DEPTH;
    span  = count + 8;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)      send(OP_SERVE, id_t'($urandom()));
      else if (pick < 85) send(OP_EXPEDITE, id_t'($urandom_range(span, 1)));
      else if (pick < 93) send(OP_EXPEDITE, id_t'($urandom()));
      else                send(OP_EXPEDITE, id_t'($urandom_range(3, 0)));
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.op          = OP_SERVE;
    in_if.item_id     = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.population = '0;
    overflow_model    = 1'b0;
    reload_rotation(id_t'(1));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default population of one, identifier zero and the top identifier
    send(OP_SERVE, ID_MAX);
    send(OP_EXPEDITE, id_t'(1));
    send(OP_EXPEDITE, id_t'(0));
    send(OP_SERVE, '0);
    send(OP_SERVE, '0);
    send(OP_EXPEDITE, ID_MAX);
    send(OP_SERVE, '0);
    send(OP_SERVE, '0);
    send(OP_SERVE, '0);

    // empty queue: serve is dropped until something is expedited
    write_population('0);
    send(OP_SERVE, ID_MAX);
    send(OP_EXPEDITE, id_t'(7));
    send(OP_SERVE, '0);
    send(OP_SERVE, '0);

    // expedite of identifiers already present, then of absent ones
    write_population(id_t'(3));
    send(OP_EXPEDITE, id_t'(3));
    send(OP_EXPEDITE, id_t'(2));
    send(OP_EXPEDITE, id_t'(30'h2AAAAAAA));
    send(OP_EXPEDITE, id_t'(30'h15555555));
    repeat (5) send(OP_SERVE, '0);

    random_phase(id_t'(1), 180);
    random_phase(id_t'(2), 180);
    random_phase(id_t'(5), 180);
    random_phase('0, 180);
    random_phase(id_t'(17), 180);
    no_gaps = 1'b1;
    random_phase(id_t'(64), 180);
    wait_idle(0);
    no_gaps = 1'b0;
    random_phase(id_t'(300), 180);
    random_phase(id_t'(1000), 180);
    random_phase(id_t'(1023), 180);
    random_phase(id_t'(DEPTH), 180);

    // full queue at the largest population: an absent identifier pushes out the tail
    write_population(ID_MAX);
    send(OP_EXPEDITE, id_t'(DEPTH));
    send(OP_EXPEDITE, id_t'(5000));
    send(OP_SERVE, '0);
    send(OP_SERVE, '0);
    random_phase(ID_MAX, 200);

    // a reload keeps the sticky flag
    write_population(id_t'(4));
    repeat (5) send(OP_SERVE, '0);

    wait_idle(2 * SETTLE_GAP);
    if (mismatches == 0 && serve_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
